>>> sv/hgrb_pkg.sv
// shared types and constants for the height grid row border finder
// no dependencies; imported by every module of the block
`default_nettype none

package hgrb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_DIM_W  = 11;
    localparam int TOL_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EQUAL_TOLERANCE = 2'd2;

    localparam logic [CFG_DIM_W-1:0] CFG_COLS_RESET = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] CFG_ROWS_RESET = 11'd1024;
    localparam logic [TOL_W-1:0]     CFG_TOL_RESET  = 16'd0;

    // result field width
    localparam int IDX_OUT_W = 10;

    typedef logic [IDX_OUT_W-1:0] t_idx_out;

    typedef struct packed {
        t_idx_out row_index;
        t_idx_out left_col;
        t_idx_out right_col;
        logic     row_kept;
        logic     frame_last;
    } t_result;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SEARCH,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> sv/hgrb_row_mem.sv
// row store: one write port, one read port with registered read data
// depends on hgrb_pkg only by project convention
`default_nettype none

module hgrb_row_mem
    import hgrb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/hgrb_ctrl.sv
// per-row sequencer: stores samples, tracks the left border, scans the row
// store backward for the right border and builds the row result
// depends on hgrb_pkg and hgrb_row_mem
`default_nettype none

module hgrb_ctrl
    import hgrb_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int ROW_W       = 10,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0] i_last_col,
    input  wire logic [ROW_W-1:0]               i_last_row,
    input  wire logic [TOL_W-1:0]               i_tol,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [HEIGHT_BITS-1:0]  i_height,
    output logic                                o_res_valid,
    output t_result                             o_res,
    input  wire logic                           i_res_take
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int HB    = HEIGHT_BITS;
    localparam int DW    = (HB + 1 > TOL_W) ? HB + 1 : TOL_W;

    t_state r_state;
    t_state n_state;

    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic signed [HB-1:0]   r_first;
    logic signed [HB-1:0]   r_final;
    logic                   r_left_found;
    logic [COL_W-1:0]       r_left_pos;
    logic                   r_right_found;
    logic [COL_W-1:0]       r_right_pos;
    logic                   r_started;
    logic                   r_ended;
    logic [COL_W-1:0]       r_addr;
    logic                   r_pend;
    logic [COL_W-1:0]       r_pend_k;

    logic                   accept;
    logic                   row_end;
    logic                   mem_re;
    logic [HB-1:0]          mem_rdata;
    logic signed [HB:0]     diff_l;
    logic signed [HB:0]     diff_r;
    logic [HB:0]            mag_l;
    logic [HB:0]            mag_r;
    logic                   left_neq;
    logic                   right_neq;
    logic                   hit;
    logic                   scan_over;
    logic                   any_border;
    logic                   started_nx;
    logic                   ended_nx;
    logic                   frame_end;

    hgrb_row_mem #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (HB)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_height),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // tolerance compares: |a - b| > tol means the heights differ
    always_comb begin
        diff_l    = {r_first[HB-1], r_first} - {i_height[HB-1], i_height};
        diff_r    = {r_final[HB-1], r_final} - {mem_rdata[HB-1], mem_rdata};
        mag_l     = diff_l[HB] ? (HB+1)'(-diff_l) : (HB+1)'(diff_l);
        mag_r     = diff_r[HB] ? (HB+1)'(-diff_r) : (HB+1)'(diff_r);
        left_neq  = DW'(mag_l) > DW'(i_tol);
        right_neq = DW'(mag_r) > DW'(i_tol);
    end

    always_comb begin
        o_in_stall = (r_state != ST_RUN);
        accept     = i_in_valid && !o_in_stall;
        row_end    = (r_col >= i_last_col);
        mem_re     = (r_state == ST_SEARCH) && (r_addr >= COL_W'(2));
        hit        = (r_state == ST_SEARCH) && r_pend && right_neq;
        scan_over  = !r_pend && (r_addr < COL_W'(2));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (accept && row_end) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit || scan_over) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // result of the row
    always_comb begin
        any_border  = r_left_found || r_right_found;
        started_nx  = any_border || r_started;
        ended_nx    = r_ended || (!any_border && r_started);
        frame_end   = (r_row >= i_last_row);
        o_res_valid = (r_state == ST_DONE);

        o_res.row_index  = t_idx_out'(r_row);
        o_res.left_col   = r_left_found ? t_idx_out'(r_left_pos) : '0;
        o_res.right_col  = r_right_found ? t_idx_out'(r_right_pos) : '0;
        o_res.row_kept   = r_left_found && r_right_found && !ended_nx;
        o_res.frame_last = frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RUN;
            r_col         <= '0;
            r_row         <= '0;
            r_first       <= '0;
            r_left_found  <= 1'b0;
            r_left_pos    <= '0;
            r_right_found <= 1'b0;
            r_started     <= 1'b0;
            r_ended       <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                if (r_col == '0) begin
                    r_first <= i_height;
                end
                if (!row_end) begin
                    if ((r_col != '0) && !r_left_found && left_neq) begin
                        r_left_found <= 1'b1;
                        r_left_pos   <= r_col;
                    end
                    r_col <= r_col + COL_W'(1);
                end else begin
                    // final column: scan starts at the column before it
                    r_final       <= i_height;
                    r_addr        <= r_col - COL_W'(1);
                    r_pend        <= 1'b0;
                    r_right_found <= 1'b0;
                end
            end

            if (r_state == ST_SEARCH) begin
                r_pend   <= mem_re;
                r_pend_k <= r_addr;
                if (mem_re) begin
                    r_addr <= r_addr - COL_W'(1);
                end
                if (hit) begin
                    r_right_found <= 1'b1;
                    r_right_pos   <= r_pend_k;
                end
            end

            if ((r_state == ST_DONE) && i_res_take) begin
                r_col        <= '0;
                r_first      <= '0;
                r_left_found <= 1'b0;
                r_left_pos   <= '0;
                if (frame_end) begin
                    r_row     <= '0;
                    r_started <= 1'b0;
                    r_ended   <= 1'b0;
                end else begin
                    r_row     <= r_row + ROW_W'(1);
                    r_started <= started_nx;
                    r_ended   <= ended_nx;
                end
            end
        end
    end

    a_row_end_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && row_end) |=> (r_state == ST_SEARCH))
        else $error("row end transaction did not start the border scan");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && r_pend) |-> (r_pend_k >= COL_W'(2)))
        else $error("border scan compared a column below two");

    a_scan_below_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> (r_addr < r_col))
        else $error("border scan read at or past the final column");

    a_take_clears_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_res_take) |=>
            (r_state == ST_RUN && r_col == '0 && !r_left_found))
        else $error("row state not cleared after result was handed over");

endmodule

`default_nettype wire

>>> sv/height_grid_row_border_finder_top.sv
// Height grid row border finder. Samples come in raster order on the input
// channel; after the final column of each row one result leaves on the output
// channel. The final sample of a row starts a backward scan of the row store
// through its single read port, one column per cycle, from the column before
// the final one down to column 2; the scan stops early at the first border.
// The input stalls from the final sample until the row result is handed over.
// A finished result waits in an output register while the next row streams in.
// The user must write configuration registers only while the block is idle;
// the block itself does not enforce this.
// depends on hgrb_pkg, hgrb_ctrl, hgrb_row_mem
`default_nettype none

module height_grid_row_border_finder_top
    import hgrb_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [HEIGHT_BITS-1:0] i_height,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [IDX_OUT_W-1:0]               o_row_index,
    output logic [IDX_OUT_W-1:0]               o_left_col,
    output logic [IDX_OUT_W-1:0]               o_right_col,
    output logic                               o_row_kept,
    output logic                               o_frame_last
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CMPW_C = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
    localparam int CMPW_R = (ROW_W + 1 > CFG_DIM_W) ? ROW_W + 1 : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] r_cfg_cols;
    logic [CFG_DIM_W-1:0] r_cfg_rows;
    logic [TOL_W-1:0]     r_cfg_tol;

    logic [CMPW_C-1:0]    cols_ext;
    logic [CMPW_R-1:0]    rows_ext;
    logic [COL_W-1:0]     last_col;
    logic [ROW_W-1:0]     last_row;

    logic                 res_valid;
    t_result              res;
    logic                 res_take;

    logic                 r_out_valid;
    t_result              r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_COLS_RESET;
            r_cfg_rows <= CFG_ROWS_RESET;
            r_cfg_tol  <= CFG_TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_COLUMNS:    r_cfg_cols <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_ROWS:       r_cfg_rows <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_EQUAL_TOLERANCE: r_cfg_tol  <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the grid size and turn it into last column / last row indexes
    always_comb begin
        cols_ext = CMPW_C'(r_cfg_cols);
        rows_ext = CMPW_R'(r_cfg_rows);

        if (cols_ext < CMPW_C'(3)) begin
            last_col = COL_W'(2);
        end else if (cols_ext > CMPW_C'(MAX_COLUMNS)) begin
            last_col = COL_W'(MAX_COLUMNS - 1);
        end else begin
            last_col = COL_W'(cols_ext - CMPW_C'(1));
        end

        if (rows_ext < CMPW_R'(1)) begin
            last_row = '0;
        end else if (rows_ext > CMPW_R'(MAX_ROWS)) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(rows_ext - CMPW_R'(1));
        end
    end

    hgrb_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_W       (ROW_W),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_last_col  (last_col),
        .i_last_row  (last_row),
        .i_tol       (r_cfg_tol),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_height    (i_height),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register: loads when empty or when its transaction completes
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_index  = r_out.row_index;
    assign o_left_col   = r_out.left_col;
    assign o_right_col  = r_out.right_col;
    assign o_row_kept   = r_out.row_kept;
    assign o_frame_last = r_out.frame_last;

endmodule

`default_nettype wire

>>> dv/tb_height_grid_row_border_finder_top.sv
// testbench for height_grid_row_border_finder_top: raster height samples in, one border
// result per row out, checked field by field against an in-bench border predictor
// depends on hgrb_pkg and the block's RTL
`timescale 1ns / 100ps

module tb_height_grid_row_border_finder_top
    import hgrb_pkg::*;
();

    localparam int MAX_COLUMNS   = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int HEIGHT_BITS   = 16;
    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    typedef logic signed [HEIGHT_BITS-1:0] t_height;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_height                i_height = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [IDX_OUT_W-1:0]   o_row_index;
    logic [IDX_OUT_W-1:0]   o_left_col;
    logic [IDX_OUT_W-1:0]   o_right_col;
    logic                   o_row_kept;
    logic                   o_frame_last;

    // stimulus and expectation stores
    t_height height_queue [$];
    t_result border_results [$];

    // handshake bookkeeping shared between the clock edges
    bit sample_taken = 1'b0;
    bit sample_pending = 1'b0;
    bit result_taken = 1'b0;
    bit idle_on = 1'b1;
    int send_gap = 0;
    int hold_left = 0;
    int error_count = 0;

    // shadow of the block's registers and state
    logic [CFG_DIM_W-1:0] cols_reg = CFG_COLS_RESET;
    logic [CFG_DIM_W-1:0] rows_reg = CFG_ROWS_RESET;
    logic [TOL_W-1:0]     tol_reg = CFG_TOL_RESET;
    t_height row_heights [0:MAX_COLUMNS-1];
    int      col_cnt = 0;
    int      row_cnt = 0;
    t_height first_h = '0;
    bit      left_hit = 1'b0;
    int      left_pos = 0;
    bit      obj_started = 1'b0;
    bit      obj_ended = 1'b0;

    height_grid_row_border_finder_top #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_height     (i_height),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_index  (o_row_index),
        .o_left_col   (o_left_col),
        .o_right_col  (o_right_col),
        .o_row_kept   (o_row_kept),
        .o_frame_last (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 100) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic int eff_columns();
        int c;
        c = int'(cols_reg);
        if (c < 3) c = 3;
        if (c > MAX_COLUMNS) c = MAX_COLUMNS;
        return c;
    endfunction

    function automatic int eff_rows();
        int r;
        r = int'(rows_reg);
        if (r < 1) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    function automatic bit heights_match(t_height a, t_height b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d <= int'(tol_reg);
    endfunction

    task automatic predict_borders(t_height h);
        int      c;
        bit      right_hit;
        int      right_pos;
        t_result r;
        c = col_cnt;
        if (c < MAX_COLUMNS) row_heights[c] = h;
        if (c == 0) first_h = h;
        if (c + 1 < eff_columns()) begin
            if (c >= 1 && !left_hit && !heights_match(first_h, h)) begin
                left_hit = 1'b1;
                left_pos = c;
            end
            col_cnt = c + 1;
        end else begin
            // scan back from the column before the final one
            right_hit = 1'b0;
            right_pos = 0;
            for (int i = c; i > 2; i--) begin
                if (!right_hit && !heights_match(h, row_heights[i-1])) begin
                    right_hit = 1'b1;
                    right_pos = i - 1;
                end
            end
            if (left_hit || right_hit) begin
                obj_started = 1'b1;
            end else if (obj_started) begin
                obj_ended = 1'b1;
            end
            r.row_index  = t_idx_out'(row_cnt);
            r.left_col   = left_hit ? t_idx_out'(left_pos) : '0;
            r.right_col  = right_hit ? t_idx_out'(right_pos) : '0;
            r.row_kept   = left_hit && right_hit && !obj_ended;
            r.frame_last = (row_cnt + 1 >= eff_rows());
            border_results.push_back(r);
            col_cnt  = 0;
            first_h  = '0;
            left_hit = 1'b0;
            left_pos = 0;
            if (r.frame_last) begin
                row_cnt     = 0;
                obj_started = 1'b0;
                obj_ended   = 1'b0;
            end else begin
                row_cnt = row_cnt + 1;
            end
        end
    endtask

    // flat, bump, step or noise row; jitter sits exactly at the tolerance edge
    task automatic queue_row(int n, int shape);
        int base;
        int far;
        int lo;
        int hi;
        int v;
        base = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 16)) - 8
                                           : int'($urandom_range(0, 65535)) - 32768;
        far = int'(tol_reg) + 1 + int'($urandom_range(0, 2));
        if ($urandom_range(0, 1) != 0) far = -far;
        lo = $urandom_range(1, n - 2);
        hi = $urandom_range(lo, n - 2);
        for (int k = 0; k < n; k++) begin
            if (shape >= 17) begin
                v = $urandom_range(0, 65535);
            end else begin
                v = base;
                if (int'(tol_reg) <= 1000 && $urandom_range(0, 1) != 0) v = base + int'(tol_reg);
                if (shape >= 5 && shape < 14 && k >= lo && k <= hi) v = base + far;
                if (shape >= 14 && k >= lo) v = base + far;
            end
            height_queue.push_back(t_height'(v));
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        unique case (idx)
            CFG_GRID_COLUMNS:    cols_reg = data[CFG_DIM_W-1:0];
            CFG_GRID_ROWS:       rows_reg = data[CFG_DIM_W-1:0];
            CFG_EQUAL_TOLERANCE: tol_reg = data[TOL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender drained, every result back, then room for a trailing sample to settle
    task automatic wait_block_idle();
        while (height_queue.size() != 0 || sample_pending || border_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_samples
        logic    next_valid;
        t_height next_height;
        next_valid  = i_in_valid;
        next_height = i_height;
        if (i_rst_n) begin
            if (sample_taken) begin
                sample_taken   = 1'b0;
                sample_pending = 1'b0;
                next_valid     = 1'b0;
                send_gap       = idle_on ? int'($urandom_range(0, 3)) : 0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (height_queue.size() != 0) begin
                    next_height    = height_queue.pop_front();
                    next_valid     = 1'b1;
                    sample_pending = 1'b1;
                end
            end
        end
        i_in_valid <= next_valid;
        i_height   <= next_height;
    end

    always @(negedge i_clk) begin : drive_stall
        if (result_taken) begin
            result_taken = 1'b0;
            hold_left    = idle_on ? int'($urandom_range(0, 3)) : 0;
        end
        i_out_stall <= (hold_left > 0);
        if (hold_left > 0 && o_out_valid) hold_left--;
    end

    always @(posedge i_clk) begin : watch_ports
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_taken = 1'b1;
                if (border_results.size() == 0) begin
                    report_mismatch("transaction with nothing expected, row_index",
                                    int'(o_row_index), -1);
                end else begin
                    want = border_results.pop_front();
                    if (o_row_index !== want.row_index)
                        report_mismatch("row_index", int'(o_row_index),
                                        int'(want.row_index));
                    if (o_left_col !== want.left_col)
                        report_mismatch("left_col", int'(o_left_col), int'(want.left_col));
                    if (o_right_col !== want.right_col)
                        report_mismatch("right_col", int'(o_right_col),
                                        int'(want.right_col));
                    if (o_row_kept !== want.row_kept)
                        report_mismatch("row_kept", int'(o_row_kept), int'(want.row_kept));
                    if (o_frame_last !== want.frame_last)
                        report_mismatch("frame_last", int'(o_frame_last),
                                        int'(want.frame_last));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                sample_taken = 1'b1;
                predict_borders(i_height);
            end
        end
    end

    initial begin : run_test
        int opening [0:22] = '{-32768, 32767, -32768, 5, 5, 5,
                               1, 2, 2, 2, 7, 7, 7, 7, 0, 5, 5, 0,
                               -32768, 32767, 0, 0, 32767};
        int random_count;
        int phase_rows;
        int k;
        logic [CFG_DATA_W-1:0] cfg_value;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // below-range sizes: three columns, one row per frame
        write_register(CFG_GRID_COLUMNS, '0);
        write_register(CFG_GRID_ROWS, '0);
        write_register(CFG_EQUAL_TOLERANCE, '0);
        for (k = 0; k < 6; k++) height_queue.push_back(t_height'(opening[k]));
        wait_block_idle();

        // left only, empty row ends the object, then a late bordered row
        write_register(CFG_GRID_COLUMNS, 16'd4);
        write_register(CFG_GRID_ROWS, 16'd3);
        for (k = 6; k < 18; k++) height_queue.push_back(t_height'(opening[k]));
        wait_block_idle();

        // widest tolerance makes full-scale heights equal
        write_register(CFG_EQUAL_TOLERANCE, '1);
        write_register(CFG_GRID_COLUMNS, 16'd5);
        for (k = 18; k < 23; k++) height_queue.push_back(t_height'(opening[k]));
        wait_block_idle();

        // above-range sizes clamp to the maximum; one full-width row
        write_register(CFG_GRID_COLUMNS, '1);
        write_register(CFG_GRID_ROWS, '1);
        write_register(CFG_EQUAL_TOLERANCE, 16'd3);
        queue_row(eff_columns(), 8);
        wait_block_idle();

        // shrink the row width partway through a row
        write_register(CFG_GRID_COLUMNS, 16'd1024);
        write_register(CFG_GRID_ROWS, 16'd1024);
        repeat (40) height_queue.push_back(t_height'($urandom));
        wait_block_idle();
        write_register(CFG_GRID_COLUMNS, 16'd10);

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            wait_block_idle();
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0: cfg_value = CFG_DATA_W'($urandom_range(0, 2));
                    1: cfg_value = CFG_DATA_W'($urandom_range(17, 48));
                    default: cfg_value = CFG_DATA_W'($urandom_range(3, 16));
                endcase
                write_register(CFG_GRID_COLUMNS, cfg_value);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0: cfg_value = '0;
                    1: cfg_value = CFG_DATA_W'($urandom_range(7, 40));
                    2: cfg_value = 16'd1024;
                    default: cfg_value = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                write_register(CFG_GRID_ROWS, cfg_value);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: cfg_value = '0;
                    1: cfg_value = '1;
                    2: cfg_value = CFG_DATA_W'($urandom_range(0, 65535));
                    default: cfg_value = CFG_DATA_W'($urandom_range(0, 4));
                endcase
                write_register(CFG_EQUAL_TOLERANCE, cfg_value);
            end
            phase_rows = $urandom_range(1, 8);
            repeat (phase_rows) begin
                queue_row(eff_columns(), $urandom_range(0, 19));
                random_count += eff_columns();
            end
            // leave a row unfinished so the next settings land mid row
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, eff_columns() - 1);
                repeat (k) height_queue.push_back(t_height'($urandom));
                random_count += k;
            end
        end

        wait_block_idle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
